// ----- rtl/rotary_cos_sin_generator_macros.svh -----
// assertion macros shared by the rotary cos/sin checker
`ifndef ROTARY_COS_SIN_GENERATOR_MACROS_SVH
`define ROTARY_COS_SIN_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define RCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotary cos/sin check failed");

// next-cycle implication, checked outside reset
`define RCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotary cos/sin check failed");

`endif

// ----- rtl/rcs_pkg.sv -----
// shared types, constants and the cordic angle table for the rotary cos/sin generator
package rcs_pkg;

  localparam logic [1:0] REG_FIRST_STEP = 2'd0;
  localparam logic [1:0] REG_FREQ_RATIO = 2'd1;
  localparam logic [1:0] REG_PAIR_COUNT = 2'd2;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd3;

  localparam logic [39:0] FIRST_STEP_RST = 40'd175000266372;
  localparam logic [31:0] FREQ_RATIO_RST = 32'd3400506952;
  localparam logic [6:0]  PAIR_COUNT_RST = 7'd64;
  localparam logic [15:0] AMPLITUDE_RST  = 16'd16384;

  // inverse cordic gain, Q0.32
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd2608131496;

  typedef enum logic [2:0] {
    MUL_AMP,
    MUL_POS_LO,
    MUL_POS_HI,
    MUL_LO_RATIO,
    MUL_HI_RATIO
  } mul_op_t;

  typedef struct packed {
    logic    take;        // latch position, restart the row
    mul_op_t mul_op;
    logic    grab_amp;    // keep scaled start vector
    logic    grab_phlo;   // keep low phase partial
    logic    rot_init;    // form phase, load cordic
    logic    grab_bsh;    // keep shifted low step product
    logic    step_adv;    // advance the frequency step
    logic    rot_step;
    logic    emit;        // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic rot_last;
    logic pair_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/rcs_ctrl.sv -----
// sequencing state machine: multiplies, cordic iterations and result hand-off
module rcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcs_pkg::dp_stat_t  stat,
  output rcs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_AMP, ST_AMPW, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_ROT, ST_EMIT
  } state_t;

  state_t state;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !stat.count_zero) state <= ST_AMP;
        end
        ST_AMP:  state <= ST_AMPW;
        ST_AMPW: state <= ST_MUL0;
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MUL3;
        ST_MUL3: state <= ST_MUL4;
        ST_MUL4: state <= ST_ROT;
        ST_ROT: begin
          if (stat.rot_last) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.out_free) state <= stat.pair_last ? ST_IDLE : ST_MUL0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = rcs_pkg::MUL_AMP;
    cmd.take      = (state == ST_IDLE) && in_valid;
    cmd.grab_amp  = (state == ST_AMPW);
    cmd.grab_phlo = (state == ST_MUL1);
    cmd.rot_init  = (state == ST_MUL2);
    cmd.grab_bsh  = (state == ST_MUL3);
    cmd.step_adv  = (state == ST_MUL4);
    cmd.rot_step  = (state == ST_ROT);
    cmd.emit      = (state == ST_EMIT) && stat.out_free;
    unique case (state)
      ST_MUL0: cmd.mul_op = rcs_pkg::MUL_POS_LO;
      ST_MUL1: cmd.mul_op = rcs_pkg::MUL_POS_HI;
      ST_MUL2: cmd.mul_op = rcs_pkg::MUL_LO_RATIO;
      ST_MUL3: cmd.mul_op = rcs_pkg::MUL_HI_RATIO;
      default: cmd.mul_op = rcs_pkg::MUL_AMP;
    endcase
  end

endmodule

// ----- rtl/rcs_dp.sv -----
// datapath: config registers, shared multiplier, iterative cordic and result register
module rcs_dp #(
  parameter int MAX_PAIRS     = 64,
  parameter int CORDIC_STAGES = 18,
  parameter int POSITION_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data,
  input  logic [19:0]        position,
  input  rcs_pkg::ctrl_cmd_t cmd,
  output rcs_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] cos_value,
  output logic signed [17:0] sin_value,
  output logic [5:0]         pair_index,
  output logic               last_pair
);

  localparam int KW = $clog2(MAX_PAIRS + 1);
  localparam int CW = (KW > 7) ? KW : 7;
  localparam int IW = $clog2(CORDIC_STAGES);

  logic [39:0] first_step;
  logic [31:0] freq_ratio;
  logic [6:0]  pair_count;
  logic [15:0] amplitude;

  logic [19:0] pos;
  logic [19:0] pos_m;
  logic [39:0] cur_step;
  logic [KW-1:0] k;
  logic [KW-1:0] n_pairs;
  logic [51:0] mreg;
  logic [19:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] x_start;
  logic [39:0] ph_lo;
  logic [39:0] phase;
  logic [31:0] bsh;
  logic [52:0] step_sum;
  logic [1:0]  quad;
  logic [IW-1:0] it;
  logic signed [35:0] x, y;
  logic signed [33:0] z;
  logic signed [35:0] dx, dy;
  logic signed [33:0] da;
  logic signed [35:0] rc, rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_step <= rcs_pkg::FIRST_STEP_RST;
      freq_ratio <= rcs_pkg::FREQ_RATIO_RST;
      pair_count <= rcs_pkg::PAIR_COUNT_RST;
      amplitude  <= rcs_pkg::AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcs_pkg::REG_FIRST_STEP: first_step <= cfg_data;
        rcs_pkg::REG_FREQ_RATIO: freq_ratio <= cfg_data[31:0];
        rcs_pkg::REG_PAIR_COUNT: pair_count <= cfg_data[6:0];
        rcs_pkg::REG_AMPLITUDE:  amplitude  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < 20; b++) pos_m[b] = position[b] & (b < POSITION_BITS);
  end

  // pair count capped at the pair limit
  assign n_pairs = (CW'(pair_count) > CW'(MAX_PAIRS)) ? KW'(MAX_PAIRS) : KW'(pair_count);

  // one shared 20 x 32 multiplier
  always_comb begin
    unique case (cmd.mul_op)
      rcs_pkg::MUL_POS_LO:   begin mul_a = pos;             mul_b = {12'd0, cur_step[19:0]}; end
      rcs_pkg::MUL_POS_HI:   begin mul_a = pos;             mul_b = {12'd0, cur_step[39:20]}; end
      rcs_pkg::MUL_LO_RATIO: begin mul_a = cur_step[19:0];  mul_b = freq_ratio; end
      rcs_pkg::MUL_HI_RATIO: begin mul_a = cur_step[39:20]; mul_b = freq_ratio; end
      default:               begin mul_a = {4'd0, amplitude}; mul_b = rcs_pkg::CORDIC_GAIN_INV; end
    endcase
  end

  assign phase    = ph_lo + {mreg[19:0], 20'd0};
  assign step_sum = {1'b0, mreg} + {21'd0, bsh};

  assign dx = y >>> it;
  assign dy = x >>> it;
  assign da = 34'(rcs_pkg::atan_turn(5'(it)));

  always_ff @(posedge clk) begin
    mreg <= 52'(mul_a * mul_b);
    if (cmd.take) begin
      pos      <= pos_m;
      cur_step <= first_step;
    end
    if (cmd.grab_amp)  x_start <= mreg[47:16];
    if (cmd.grab_phlo) ph_lo   <= mreg[39:0];
    if (cmd.grab_bsh)  bsh     <= mreg[51:20];
    if (cmd.step_adv)  cur_step <= step_sum[51:12];
    if (cmd.rot_init) begin
      x    <= {4'd0, x_start};
      y    <= '0;
      z    <= {4'd0, phase[37:8]};
      quad <= phase[39:38];
    end else if (cmd.rot_step) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it <= '0;
      k  <= '0;
    end else begin
      if (cmd.rot_init) it <= '0;
      else if (cmd.rot_step) it <= it + 1'b1;
      if (cmd.take) k <= '0;
      else if (cmd.emit) k <= stat.pair_last ? '0 : k + 1'b1;
    end
  end

  function automatic logic signed [17:0] to_q15(input logic signed [35:0] v);
    logic signed [36:0] r;
    r = (37'(v) + 37'sd16384) >>> 15;
    if (r > 37'sd131071) return 18'sd131071;
    if (r < -37'sd131072) return -18'sd131072;
    return r[17:0];
  endfunction

  always_comb begin
    unique case (quad)
      2'd0:    begin rc = x;  rs = y;  end
      2'd1:    begin rc = -y; rs = x;  end
      2'd2:    begin rc = -x; rs = -y; end
      default: begin rc = y;  rs = -x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cos_value  <= to_q15(rc);
      sin_value  <= to_q15(rs);
      pair_index <= 6'(k);
      last_pair  <= stat.pair_last;
    end
  end

  always_comb begin
    stat.count_zero = (n_pairs == '0);
    stat.rot_last   = (it == IW'(CORDIC_STAGES - 1));
    stat.pair_last  = (KW'(k + 1'b1) == n_pairs);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/rotary_cos_sin_generator.sv -----
// rotary cos/sin row generator: per position, one scaled cos/sin beat per dimension pair
// first beat: amplitude scaling in ST_AMP and ST_AMPW, then the per-beat sequence below
// per beat: multiplies in ST_MUL0 to ST_MUL4, cordic iterations in ST_ROT, hand-off in ST_EMIT, where
// out_stall can hold it; the pace is set by the shared multiplier and the one-stage cordic loop
// a new position is taken only once the previous row has been issued
// reset: registers return to their defaults, no beat pending, block ready for a position
module rotary_cos_sin_generator #(
  parameter int MAX_PAIRS     = 64,
  parameter int CORDIC_STAGES = 18,
  parameter int POSITION_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] cos_value,
  output logic signed [17:0] sin_value,
  output logic [5:0]         pair_index,
  output logic               last_pair
);

  rcs_pkg::ctrl_cmd_t cmd;
  rcs_pkg::dp_stat_t  stat;

  rcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcs_dp #(
    .MAX_PAIRS     (MAX_PAIRS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .position   (position),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cos_value  (cos_value),
    .sin_value  (sin_value),
    .pair_index (pair_index),
    .last_pair  (last_pair)
  );

endmodule

// ----- rtl/rcs_checker.sv -----
// port-level checks for the rotary cos/sin generator, bound to the top level
`include "rotary_cos_sin_generator_macros.svh"

module rcs_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] cos_value,
  input logic signed [17:0] sin_value,
  input logic [5:0]         pair_index,
  input logic               last_pair
);

  // a row still in flight keeps the input side closed
  `RCS_ASSERT_NOW(a_row_busy, out_valid && !last_pair, in_stall)

  // no beat can appear in the cycle after a position is taken
  `RCS_ASSERT_NEXT(a_no_early_beat, in_valid && !in_stall && !out_valid, !out_valid)

  // a stalled beat holds
  `RCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(cos_value) && $stable(sin_value) && $stable(pair_index) && $stable(last_pair))

endmodule

bind rotary_cos_sin_generator rcs_port_checker u_rcs_checker (.*);
